FILE: sv/uds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uds_pkg
// shared types and protocol codes for the uds single-frame responder
// ----------------------------------------------------------------------------
package uds_pkg;

  localparam int ID_W    = 11;
  localparam int FLEN_W  = 3;
  localparam int NBYTES  = 8;

  typedef logic [7:0] byte_t;
  typedef byte_t [NBYTES-1:0] frame_t;

  // iso-tp and uds codes
  localparam logic [3:0] PCI_SF      = 4'h0;
  localparam byte_t      NEG_SID     = 8'h7F;
  localparam byte_t      POS_OFFSET  = 8'h40;
  localparam byte_t      NRC_SNS     = 8'h11;
  localparam byte_t      NRC_LEN     = 8'h13;
  localparam byte_t      NRC_RANGE   = 8'h31;
  localparam byte_t      SVC_CLEAR   = 8'h14;
  localparam byte_t      SVC_READ    = 8'h19;
  localparam byte_t      SVC_WRITE   = 8'h2E;
  localparam byte_t      SUB_COUNT   = 8'h01;
  localparam byte_t      SUB_LIST    = 8'h02;
  localparam byte_t      INJECT_HI   = 8'hF1;
  localparam byte_t      INJECT_LO   = 8'hA0;
  localparam byte_t      DTC_STATUS  = 8'h40;
  localparam byte_t      PAD_BYTE    = 8'h00;

  typedef struct packed {
    logic [ID_W-1:0]   can_id;
    logic [FLEN_W-1:0] frame_len;
    frame_t            data;
  } rsp_t;

  typedef struct packed {
    logic  present;
    byte_t code;
  } rec_t;

  typedef struct packed {
    logic  clear;
    logic  write;
    byte_t code;
  } rec_upd_t;

endpackage
`default_nettype wire

FILE: sv/uds_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uds channel interfaces
// valid/ready channels for request frames, response frames and configuration
// ----------------------------------------------------------------------------
interface uds_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte0;
  logic [7:0] frame_byte1;
  logic [7:0] frame_byte2;
  logic [7:0] frame_byte3;
  logic [7:0] frame_byte4;
  logic [7:0] frame_byte5;
  logic [7:0] frame_byte6;
  logic [7:0] frame_byte7;
  modport source (output valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                  frame_byte4, frame_byte5, frame_byte6, frame_byte7, input ready);
  modport sink (input valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                frame_byte4, frame_byte5, frame_byte6, frame_byte7, output ready);
endinterface

interface uds_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] can_id;
  logic [2:0]  frame_len;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic [7:0]  out_byte3;
  logic [7:0]  out_byte4;
  logic [7:0]  out_byte5;
  logic [7:0]  out_byte6;
  logic [7:0]  out_byte7;
  modport source (output valid, can_id, frame_len, out_byte0, out_byte1, out_byte2,
                  out_byte3, out_byte4, out_byte5, out_byte6, out_byte7, input ready);
  modport sink (input valid, can_id, frame_len, out_byte0, out_byte1, out_byte2,
                out_byte3, out_byte4, out_byte5, out_byte6, out_byte7, output ready);
endinterface

interface uds_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: sv/uds_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uds_in_stage
// input register holding one request frame until decode hands it on
// ----------------------------------------------------------------------------
module uds_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire uds_pkg::frame_t in_frame,
  input  wire logic            advance,
  output      logic            held_valid,
  output      uds_pkg::frame_t held_frame
);
  import uds_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_frame <= in_frame;
    end
  end

endmodule
`default_nettype wire

FILE: sv/uds_record.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uds_record
// latest stored fault record, cleared or written by decoded requests
// ----------------------------------------------------------------------------
module uds_record (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              commit,
  input  wire uds_pkg::rec_upd_t upd,
  output      uds_pkg::rec_t     rec
);
  import uds_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (commit) begin
      if (upd.write) begin
        rec.present <= 1'b1;
        rec.code    <= upd.code;
      end else if (upd.clear) begin
        rec.present <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/uds_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uds_decode
// single-frame check, service decode, response build and record update
// ----------------------------------------------------------------------------
module uds_decode (
  input  wire uds_pkg::frame_t            frame,
  input  wire uds_pkg::rec_t              rec,
  input  wire logic [uds_pkg::ID_W-1:0]   response_id,
  output      uds_pkg::rsp_t              rsp,
  output      uds_pkg::rec_upd_t          upd
);
  import uds_pkg::*;

  logic [3:0] len;
  logic       is_sf;
  logic       did_ok;
  logic [2:0] n;
  byte_t      r [5];

  assign len    = frame[0][3:0];
  assign is_sf  = (frame[0][7:4] == PCI_SF);
  assign did_ok = (frame[2] == INJECT_HI) && (frame[3] == INJECT_LO);

  always_comb begin
    n         = 3'd3;
    r[0]      = NEG_SID;
    r[1]      = PAD_BYTE;
    r[2]      = NRC_LEN;
    r[3]      = PAD_BYTE;
    r[4]      = PAD_BYTE;
    upd.clear = 1'b0;
    upd.write = 1'b0;
    upd.code  = frame[5];
    if (is_sf && len != 4'd0) begin
      r[1] = frame[1];
      case (frame[1])
        SVC_CLEAR: begin
          if (len == 4'd1) begin
            upd.clear = 1'b1;
            n         = 3'd1;
            r[0]      = SVC_CLEAR + POS_OFFSET;
            r[1]      = PAD_BYTE;
            r[2]      = PAD_BYTE;
          end
        end
        SVC_READ: begin
          if (len >= 4'd2) begin
            if (frame[2] == SUB_COUNT) begin
              n    = 3'd4;
              r[0] = SVC_READ + POS_OFFSET;
              r[1] = frame[2];
              r[2] = PAD_BYTE;
              r[3] = {7'd0, rec.present};
            end else if (frame[2] == SUB_LIST) begin
              r[0] = SVC_READ + POS_OFFSET;
              r[1] = frame[2];
              r[2] = PAD_BYTE;
              if (rec.present) begin
                n    = 3'd5;
                r[3] = rec.code;
                r[4] = DTC_STATUS;
              end else begin
                n    = 3'd2;
              end
            end else begin
              r[2] = NRC_RANGE;
            end
          end
        end
        SVC_WRITE: begin
          if (len >= 4'd3) begin
            if (!did_ok) begin
              r[2] = NRC_RANGE;
            end else if (len >= 4'd5) begin
              upd.write = 1'b1;
              r[0]      = SVC_WRITE + POS_OFFSET;
              r[1]      = frame[2];
              r[2]      = frame[3];
            end
          end
        end
        default: begin
          r[2] = NRC_SNS;
        end
      endcase
    end
  end

  always_comb begin
    rsp.can_id    = response_id;
    rsp.frame_len = n + 3'd1;
    rsp.data[0]   = {5'd0, n};
    rsp.data[1]   = r[0];
    rsp.data[2]   = r[1];
    rsp.data[3]   = r[2];
    rsp.data[4]   = r[3];
    rsp.data[5]   = r[4];
    rsp.data[6]   = PAD_BYTE;
    rsp.data[7]   = PAD_BYTE;
  end

endmodule
`default_nettype wire

FILE: sv/uds_single_frame_responder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uds_single_frame_responder
// answers each iso-tp single-frame uds request with one padded response frame
// ----------------------------------------------------------------------------
// a request beat is registered in the input stage and moves on into the result
//   register when the output side is free (two register stages: input, result)
// throughput: one beat per cycle unless rsp_out stalls, set by both registers
// reset: synchronous; both stages empty, no record stored, response id zero
// ----------------------------------------------------------------------------
module uds_single_frame_responder (
  input  wire logic clk,
  input  wire logic rst,
  uds_cfg_if.sink   cfg,
  uds_frame_if.sink frame_in,
  uds_rsp_if.source rsp_out
);
  import uds_pkg::*;

  // configuration: response identifier, writes always taken
  logic [ID_W-1:0] response_id;

  // input stage
  frame_t   in_frame;
  logic     held_valid;
  frame_t   held_frame;
  logic     advance;

  // record and decode
  rec_t     rec;
  rec_upd_t upd;
  rsp_t     rsp_next;

  // result register
  logic     out_valid;
  rsp_t     rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_id <= '0;
    end else if (cfg.valid) begin
      response_id <= cfg.data;
    end
  end

  assign in_frame[0] = frame_in.frame_byte0;
  assign in_frame[1] = frame_in.frame_byte1;
  assign in_frame[2] = frame_in.frame_byte2;
  assign in_frame[3] = frame_in.frame_byte3;
  assign in_frame[4] = frame_in.frame_byte4;
  assign in_frame[5] = frame_in.frame_byte5;
  assign in_frame[6] = frame_in.frame_byte6;
  assign in_frame[7] = frame_in.frame_byte7;

  // the held request moves on whenever the result register is free or draining
  assign advance = held_valid && (!out_valid || rsp_out.ready);

  uds_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (frame_in.valid),
    .in_ready   (frame_in.ready),
    .in_frame   (in_frame),
    .advance    (advance),
    .held_valid (held_valid),
    .held_frame (held_frame)
  );

  // decode sees the record as left by all earlier requests, since the
  // record only changes as a request moves into the result register
  uds_decode u_decode (
    .frame       (held_frame),
    .rec         (rec),
    .response_id (response_id),
    .rsp         (rsp_next),
    .upd         (upd)
  );

  uds_record u_record (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .upd    (upd),
    .rec    (rec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  assign rsp_out.valid     = out_valid;
  assign rsp_out.can_id    = rsp.can_id;
  assign rsp_out.frame_len = rsp.frame_len;
  assign rsp_out.out_byte0 = rsp.data[0];
  assign rsp_out.out_byte1 = rsp.data[1];
  assign rsp_out.out_byte2 = rsp.data[2];
  assign rsp_out.out_byte3 = rsp.data[3];
  assign rsp_out.out_byte4 = rsp.data[4];
  assign rsp_out.out_byte5 = rsp.data[5];
  assign rsp_out.out_byte6 = rsp.data[6];
  assign rsp_out.out_byte7 = rsp.data[7];

  // frame length always agrees with the pci length, padding always zero
  a_len_pci: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rsp.frame_len == rsp.data[0][2:0] + 3'd1)
      && (rsp.data[6] == PAD_BYTE) && (rsp.data[7] == PAD_BYTE))
    else $error("response length and pci disagree or padding not zero");

  // a negative response is always three uds bytes
  a_neg_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rsp.data[1] == NEG_SID) |-> (rsp.frame_len == 3'd4))
    else $error("negative response with wrong length");

  // a held request that cannot move on stays held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !advance) |=> held_valid)
    else $error("held request lost while stalled");

  // a committed write leaves a record present
  a_write: assert property (@(posedge clk) disable iff (rst)
    (advance && upd.write) |=> rec.present)
    else $error("record missing after write");

endmodule
`default_nettype wire
